>>> rtl/psa_pkg.sv
// Package for the Pearson similarity accumulator: default widths, the queue depth
// and the back-end state type, used by the front end, the queue and the back end.
`timescale 1ns / 1ps

package psa_pkg;

  localparam int MaxUsersDefault = 4096;
  localparam int RatingBitsDefault = 8;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ROOT,
    BK_DONE
  } bk_state_t;

endpackage

>>> rtl/psa_front.sv
// Front end: takes rating pairs, keeps the running sums and, on the last user,
// passes a frozen snapshot of the sums to the request queue.
// Depends on psa_pkg.
`timescale 1ns / 1ps

module psa_front #(
  parameter int MAX_USERS = psa_pkg::MaxUsersDefault,
  parameter int RATING_BITS = psa_pkg::RatingBitsDefault,
  parameter int CW = $clog2(MAX_USERS + 1),
  parameter int SW = RATING_BITS + CW,
  parameter int QW = 2 * RATING_BITS + CW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [RATING_BITS-1:0] x,
  input  logic [RATING_BITS-1:0] y,
  input  logic                   last,
  output logic                   req_valid,
  input  logic                   req_ready,
  output logic [CW-1:0]          req_n,
  output logic [SW-1:0]          req_sx,
  output logic [SW-1:0]          req_sy,
  output logic [QW-1:0]          req_sxx,
  output logic [QW-1:0]          req_syy,
  output logic [QW-1:0]          req_sxy
);

  logic [CW-1:0] n;
  logic [SW-1:0] sx, sy;
  logic [QW-1:0] sxx, syy, sxy;
  logic          take;
  logic          count_it;
  logic [CW-1:0] n_next;
  logic [SW-1:0] sx_next, sy_next;
  logic [QW-1:0] sxx_next, syy_next, sxy_next;

  // A last item needs a free queue slot; other items never stall.
  assign in_ready = !last || req_ready;
  assign take = in_valid && in_ready;
  assign count_it = (x != '0) && (y != '0) && (n < CW'(MAX_USERS));

  always_comb begin
    n_next = n;
    sx_next = sx;
    sy_next = sy;
    sxx_next = sxx;
    syy_next = syy;
    sxy_next = sxy;
    if (count_it) begin
      n_next = n + CW'(1);
      sx_next = sx + SW'(x);
      sy_next = sy + SW'(y);
      sxx_next = sxx + QW'(x * x);
      syy_next = syy + QW'(y * y);
      sxy_next = sxy + QW'(x * y);
    end
  end

  assign req_valid = take && last;
  assign req_n = n_next;
  assign req_sx = sx_next;
  assign req_sy = sy_next;
  assign req_sxx = sxx_next;
  assign req_syy = syy_next;
  assign req_sxy = sxy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      sx <= '0;
      sy <= '0;
      sxx <= '0;
      syy <= '0;
      sxy <= '0;
    end else if (take) begin
      if (last) begin
        n <= '0;
        sx <= '0;
        sy <= '0;
        sxx <= '0;
        syy <= '0;
        sxy <= '0;
      end else begin
        n <= n_next;
        sx <= sx_next;
        sy <= sy_next;
        sxx <= sxx_next;
        syy <= syy_next;
        sxy <= sxy_next;
      end
    end
  end

endmodule

>>> rtl/psa_queue.sv
// Small request queue between the front end and the back end.
// Depends on psa_pkg for its depth.
`timescale 1ns / 1ps

module psa_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int AW = $clog2(psa_pkg::QueueDepth);

  logic [W-1:0] mem [psa_pkg::QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] fill;
  logic wr, rd;

  assign wr_ready = fill != (AW + 1)'(psa_pkg::QueueDepth);
  assign rd_valid = fill != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (wr) begin
        wp <= wp + AW'(1);
      end
      if (rd) begin
        rp <= rp + AW'(1);
      end
      fill <= fill + (AW + 1)'(wr) - (AW + 1)'(rd);
    end
  end

endmodule

>>> rtl/psa_back.sv
// Back end: from a sums snapshot forms the centered sums, builds the two wide
// cross products on one shared multiplier and finds the Q1.15 correlation one bit per pass.
// Depends on psa_pkg for the state type.
`timescale 1ns / 1ps

module psa_back #(
  parameter int CW = 13,
  parameter int SW = 21,
  parameter int QW = 29
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  logic [CW-1:0] req_n,
  input  logic [SW-1:0] req_sx,
  input  logic [SW-1:0] req_sy,
  input  logic [QW-1:0] req_sxx,
  input  logic [QW-1:0] req_syy,
  input  logic [QW-1:0] req_sxy,
  output logic          res_valid,
  input  logic          res_ready,
  output logic [15:0]   res_sim,
  output logic [12:0]   res_count,
  output logic          res_defined
);

  localparam int PW = CW + QW;
  localparam int LW = (PW + 1) / 2;
  localparam int AW = 2 * PW;
  localparam int QAW = AW + 17;
  localparam int TW = AW + 32;
  localparam int MulLast = 8;

  psa_pkg::bk_state_t state, state_next;
  logic [3:0] step;
  logic [3:0] bitpos;
  logic [CW-1:0] n;
  logic [PW-1:0] nxx, xx2, nyy, yy2, px, py;
  logic [PW-1:0] sxx, syy, sxy;
  logic [PW-1:0] src_x, src_y;
  logic [AW-1:0] a, bsq;
  logic [QAW-1:0] qa;
  logic [TW-1:0] q2a, s1, t;
  logic [15:0] q;
  logic [15:0] cand;
  logic [LW-1:0] op_x, op_y;
  logic [2*LW-1:0] prod;
  logic [1:0] pos;
  logic [AW-1:0] term;
  logic fits;

  function automatic logic [LW-1:0] lo_half(input logic [PW-1:0] v);
    return v[LW-1:0];
  endfunction

  function automatic logic [LW-1:0] hi_half(input logic [PW-1:0] v);
    return LW'(v[PW-1:LW]);
  endfunction

  // Each wide product is the sum of four half-width partial products.
  always_comb begin
    src_x = (step <= 4'd4) ? sxx : sxy;
    src_y = (step <= 4'd4) ? syy : sxy;
    op_x = '0;
    op_y = '0;
    pos = 2'd0;
    case (step)
      4'd1, 4'd5: begin
        op_x = lo_half(src_x);
        op_y = lo_half(src_y);
      end
      4'd2, 4'd6: begin
        op_x = lo_half(src_x);
        op_y = hi_half(src_y);
        pos = 2'd1;
      end
      4'd3, 4'd7: begin
        op_x = hi_half(src_x);
        op_y = lo_half(src_y);
        pos = 2'd1;
      end
      4'd4, 4'd8: begin
        op_x = hi_half(src_x);
        op_y = hi_half(src_y);
        pos = 2'd2;
      end
      default: pos = 2'd0;
    endcase
  end

  assign prod = (2*LW)'(op_x) * (2*LW)'(op_y);

  always_comb begin
    case (pos)
      2'd0: term = AW'(prod);
      2'd1: term = AW'(prod) << LW;
      default: term = AW'(prod) << (2 * LW);
    endcase
  end

  // With c = q + 2^k, c^2*a = q^2*a + (q*a << (k+1)) + (a << 2k).
  assign cand = q | (16'(1) << bitpos);
  assign t = s1 + (TW'(a) << {bitpos, 1'b0});
  assign fits = t <= (TW'(bsq) << 30);
  assign req_ready = (state == psa_pkg::BK_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      psa_pkg::BK_IDLE: if (req_valid) state_next = psa_pkg::BK_MUL;
      psa_pkg::BK_MUL: if (step == 4'(MulLast)) state_next = psa_pkg::BK_ROOT;
      psa_pkg::BK_ROOT: if (bitpos == 4'd0 && step == 4'd1) state_next = psa_pkg::BK_DONE;
      psa_pkg::BK_DONE: if (res_ready) state_next = psa_pkg::BK_IDLE;
      default: state_next = psa_pkg::BK_IDLE;
    endcase
  end

  assign res_valid = (state == psa_pkg::BK_DONE);
  assign res_sim = q;
  assign res_count = 13'(n);
  assign res_defined = (n != '0) && (sxx != '0) && (syy != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psa_pkg::BK_IDLE;
      step <= '0;
      bitpos <= 4'd15;
    end else begin
      state <= state_next;
      case (state)
        psa_pkg::BK_IDLE: begin
          step <= '0;
          bitpos <= 4'd15;
        end
        psa_pkg::BK_MUL: step <= (step == 4'(MulLast)) ? 4'd0 : step + 4'd1;
        psa_pkg::BK_ROOT: begin
          step <= (step == 4'd1) ? 4'd0 : step + 4'd1;
          if (step == 4'd1) begin
            bitpos <= bitpos - 4'd1;
          end
        end
        default: step <= '0;
      endcase
    end
  end

  // Datapath: capture products, centered sums, wide products, then one bit per pass.
  always_ff @(posedge clk) begin
    case (state)
      psa_pkg::BK_IDLE: begin
        n <= req_n;
        nxx <= PW'(req_n) * PW'(req_sxx);
        xx2 <= PW'(req_sx) * PW'(req_sx);
        nyy <= PW'(req_n) * PW'(req_syy);
        yy2 <= PW'(req_sy) * PW'(req_sy);
        px <= PW'(req_n) * PW'(req_sxy);
        py <= PW'(req_sx) * PW'(req_sy);
        q <= '0;
        qa <= '0;
        q2a <= '0;
      end
      psa_pkg::BK_MUL: begin
        if (step == 4'd0) begin
          // n*sum >= sum^2 holds, so these differences never wrap.
          sxx <= nxx - xx2;
          syy <= nyy - yy2;
          sxy <= (px >= py) ? px - py : py - px;
          a <= '0;
          bsq <= '0;
        end else if (step <= 4'd4) begin
          a <= a + term;
        end else begin
          bsq <= bsq + term;
        end
      end
      psa_pkg::BK_ROOT: begin
        if (step == 4'd0) begin
          s1 <= q2a + (TW'(qa) << (5'(bitpos) + 5'd1));
        end else if (res_defined && fits) begin
          q <= cand;
          q2a <= t;
          qa <= qa + (QAW'(a) << bitpos);
        end
      end
      default: q <= q;
    endcase
  end

endmodule

>>> rtl/pearson_similarity_accumulator.sv
// Top level of the Pearson similarity accumulator.
// Depends on psa_pkg, psa_front, psa_queue and psa_back.
//
// Usage: rating pairs stream in on the s_axis group, one user per request,
// tdata = {rating_y, rating_x} (rating_x lowest), tuser = last_user. Pairs
// where both ratings are nonzero add to the count and the sums; the count
// saturates at MAX_USERS. A request with last_user set closes the vector.
// One result per closed vector leaves on m_axis, tdata holding similarity
// (bits 15:0, |r| in Q1.15, truncated), common_count (28:16), defined (29).
// Ordinary pairs are taken at one per cycle. A closing request is taken when
// the four-entry queue has room. The back end picks the snapshot up from the
// queue once it is idle, forms the centered sums, builds the two wide products,
// each from four passes of one shared half-width multiplier, then finds sixteen
// result bits one per pass and shows the result. It takes no new snapshot until
// that result has been taken, so closely spaced vectors wait in the queue. Reset
// clears the sums, the queue and the back end. When the receiver stalls the
// result holds, the queue fills, and further closing requests wait.
`timescale 1ns / 1ps

module pearson_similarity_accumulator #(
  parameter int MAX_USERS = psa_pkg::MaxUsersDefault,
  parameter int RATING_BITS = psa_pkg::RatingBitsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // rating_x, rating_y
  input  logic [2*RATING_BITS-1:0] s_axis_tdata,
  // last_user
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // similarity, common_count, defined, zero pad
  output logic [31:0]              m_axis_tdata
);

  localparam int CW = $clog2(MAX_USERS + 1);
  localparam int SW = RATING_BITS + CW;
  localparam int QW = 2 * RATING_BITS + CW;
  localparam int RW = CW + 2 * SW + 3 * QW;

  logic f_valid, f_ready, b_valid, b_ready;
  logic [CW-1:0] f_n, b_n;
  logic [SW-1:0] f_sx, f_sy, b_sx, b_sy;
  logic [QW-1:0] f_sxx, f_syy, f_sxy, b_sxx, b_syy, b_sxy;
  logic [15:0] sim;
  logic [12:0] cnt;
  logic def;

  psa_front #(.MAX_USERS(MAX_USERS), .RATING_BITS(RATING_BITS),
    .CW(CW), .SW(SW), .QW(QW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .x(s_axis_tdata[RATING_BITS-1:0]),
    .y(s_axis_tdata[2*RATING_BITS-1:RATING_BITS]),
    .last(s_axis_tuser),
    .req_valid(f_valid), .req_ready(f_ready),
    .req_n(f_n), .req_sx(f_sx), .req_sy(f_sy),
    .req_sxx(f_sxx), .req_syy(f_syy), .req_sxy(f_sxy)
  );

  psa_queue #(.W(RW)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_n, f_sx, f_sy, f_sxx, f_syy, f_sxy}),
    .rd_valid(b_valid), .rd_ready(b_ready),
    .rd_data({b_n, b_sx, b_sy, b_sxx, b_syy, b_sxy})
  );

  psa_back #(.CW(CW), .SW(SW + 1), .QW(QW + 1)) u_back (
    .clk(clk), .rst(rst),
    .req_valid(b_valid), .req_ready(b_ready),
    .req_n(b_n), .req_sx({1'b0, b_sx}), .req_sy({1'b0, b_sy}),
    .req_sxx({1'b0, b_sxx}), .req_syy({1'b0, b_syy}), .req_sxy({1'b0, b_sxy}),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_sim(sim), .res_count(cnt), .res_defined(def)
  );

  assign m_axis_tdata = {2'b00, def, cnt, sim};

  a_sim_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> sim <= 16'd32768) else $error("similarity above one");
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !def) |-> sim == 16'd0) else $error("undefined result not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

endmodule

>>> sim/pearson_similarity_accumulator_test.sv
// Testbench for the Pearson similarity accumulator: streams rating pairs with
// random idling on both sides and checks each similarity result against a predictor.
// Depends on psa_pkg and pearson_similarity_accumulator.
`timescale 1ns / 1ps

module pearson_similarity_accumulator_test;

  localparam int MaxUsers = psa_pkg::MaxUsersDefault;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 100;
  localparam int PhaseItems = 512;

  typedef struct packed {
    logic [7:0] rating_x;
    logic [7:0] rating_y;
    logic       last_user;
  } pair_req_t;

  typedef struct packed {
    logic [15:0] similarity;
    logic [12:0] common_count;
    logic        defined;
  } sim_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  pearson_similarity_accumulator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pair_req_t   pending_pairs[$];
  sim_result_t expected_scores[$];
  int          send_idle_pct = 14;
  int          recv_idle_pct = 82;
  int          errors = 0;
  int          idle_cycles = 0;
  int          vectors_closed = 0;
  int          undefined_seen = 0;

  // Handshake seen at the last rising edge, so the driver knows the request left.
  logic s_axis_tready_q = 1'b0;

  // Running co-rated statistics, as the block keeps them.
  longint unsigned acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy;

  // Largest q with q^2 * sxx * syy <= 2^30 * sxy^2, in 200-bit arithmetic.
  function automatic logic [15:0] root_ratio(longint unsigned sxx, longint unsigned syy,
                                             longint unsigned sxy);
    logic [199:0] lhs;
    logic [199:0] rhs;
    logic [16:0]  q;
    logic [16:0]  c;
    q = '0;
    rhs = (200'(sxy) * 200'(sxy)) << 30;
    for (int b = 15; b >= 0; b--) begin
      c = q | (17'd1 << b);
      lhs = 200'(c) * 200'(c) * 200'(sxx) * 200'(syy);
      if (lhs <= rhs) q = c;
    end
    return q[15:0];
  endfunction

  function automatic void predict_pair(pair_req_t p);
    longint unsigned x, y, sxx, syy, px, py, sxy;
    sim_result_t r;
    x = p.rating_x;
    y = p.rating_y;
    if (x != 0 && y != 0 && acc_n < MaxUsers) begin
      acc_n++;
      acc_x += x;
      acc_y += y;
      acc_xx += x * x;
      acc_yy += y * y;
      acc_xy += x * y;
    end
    if (!p.last_user) return;
    r = '0;
    r.common_count = acc_n[12:0];
    if (acc_n != 0) begin
      sxx = acc_n * acc_xx - acc_x * acc_x;
      syy = acc_n * acc_yy - acc_y * acc_y;
      px = acc_n * acc_xy;
      py = acc_x * acc_y;
      sxy = (px >= py) ? px - py : py - px;
      if (sxx != 0 && syy != 0) begin
        r.defined = 1'b1;
        r.similarity = root_ratio(sxx, syy, sxy);
      end
    end
    expected_scores.push_back(r);
    {acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
  endfunction

  function automatic pair_req_t make_pair(int x, int y, bit last);
    pair_req_t p;
    p.rating_x = x[7:0];
    p.rating_y = y[7:0];
    p.last_user = last;
    return p;
  endfunction

  // Driver: a request stays up until taken, then the next one is loaded.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready_q) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_req_t p;
          p = pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {p.rating_y, p.rating_x};
          s_axis_tuser <= p.last_user;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    s_axis_tready_q <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_pair(make_pair(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tuser));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sim_result_t got;
        got = {m_axis_tdata[15:0], m_axis_tdata[28:16], m_axis_tdata[29]};
        if (expected_scores.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, m_axis_tdata);
          errors++;
        end else begin
          sim_result_t want;
          want = expected_scores.pop_front();
          if (got.similarity !== want.similarity) begin
            $display("%0t: similarity expected %0d actual %0d", $realtime,
                     want.similarity, got.similarity);
            errors++;
          end
          if (got.common_count !== want.common_count) begin
            $display("%0t: common_count expected %0d actual %0d", $realtime,
                     want.common_count, got.common_count);
            errors++;
          end
          if (got.defined !== want.defined) begin
            $display("%0t: defined expected %0b actual %0b", $realtime,
                     want.defined, got.defined);
            errors++;
          end
          if (!want.defined) undefined_seen++;
        end
        vectors_closed++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (pending_pairs.size() == 0 && expected_scores.size() == 0 && !s_axis_tvalid))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_vector(int users, int rated_pct, bit correlated);
    int base;
    int x;
    int y;
    base = $urandom_range(255);
    for (int i = 0; i < users; i++) begin
      x = ($urandom_range(99) < rated_pct) ? $urandom_range(255) : 0;
      if (correlated) y = (x + base) % 256;
      else y = ($urandom_range(99) < rated_pct) ? $urandom_range(255) : 0;
      pending_pairs.push_back(make_pair(x, y, i == users - 1));
    end
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || s_axis_tvalid || expected_scores.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int queued;
    int users;
    {acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty vector, a lone pair, zero variance, perfect and inverse
    // correlation, extreme ratings, unrated users mixed with rated ones.
    pending_pairs.push_back(make_pair(0, 0, 1'b1));
    pending_pairs.push_back(make_pair(255, 255, 1'b1));
    pending_pairs.push_back(make_pair(5, 1, 1'b0));
    pending_pairs.push_back(make_pair(9, 1, 1'b1));
    pending_pairs.push_back(make_pair(1, 1, 1'b0));
    pending_pairs.push_back(make_pair(128, 128, 1'b0));
    pending_pairs.push_back(make_pair(255, 255, 1'b1));
    pending_pairs.push_back(make_pair(1, 255, 1'b0));
    pending_pairs.push_back(make_pair(255, 1, 1'b0));
    pending_pairs.push_back(make_pair(170, 85, 1'b1));
    pending_pairs.push_back(make_pair(0, 200, 1'b0));
    pending_pairs.push_back(make_pair(200, 0, 1'b0));
    pending_pairs.push_back(make_pair(85, 170, 1'b0));
    pending_pairs.push_back(make_pair(3, 7, 1'b0));
    pending_pairs.push_back(make_pair(0, 0, 1'b1));
    // The sender waits until every result is back.
    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 82 : 0;
      recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 14 : 0;
      queued = 0;
      while (queued < PhaseItems) begin
        if ($urandom_range(9) == 0) begin
          users = $urandom_range(3, 1);
          queue_vector(users, 50, 1'b0);
        end else begin
          users = $urandom_range(12, 2);
          queue_vector(users, $urandom_range(100, 60), $urandom_range(3) == 0);
        end
        queued += users;
      end
      wait_drained();
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Closed %0d vectors (%0d undefined), including empty, flat and extreme",
             vectors_closed, undefined_seen);
    $display("vectors under three idling mixes on both sides.");
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> pearson_similarity_accumulator.f
rtl/psa_pkg.sv
rtl/psa_front.sv
rtl/psa_queue.sv
rtl/psa_back.sv
rtl/pearson_similarity_accumulator.sv
sim/pearson_similarity_accumulator_test.sv
